// File: rtl/sae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

    localparam int OP_W       = 2;
    localparam int TIDX_W     = 9;
    localparam int TVAL_W     = 14;
    localparam int SYM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int ENDSYM_W   = 9;
    localparam int RIDX_W     = 10;
    localparam int FREE_W     = 4;

    localparam int MAX_RESULTS = 64;
    localparam int RES_AW      = 6;
    localparam int RES_CW      = 7;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [ENDSYM_W-1:0] END_SYMBOL_RST = 9'd256;
    localparam logic [FREE_W-1:0]   FREE_FULL      = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIDX_W-1:0] table_index;
        logic [TVAL_W-1:0] table_value;
        logic [SYM_W-1:0]  symbol;
    } t_cmd;

    typedef struct packed {
        logic              wr;
        logic [BYTE_W-1:0] data;
        logic              done;
        logic              ovf;
    } t_wr;

endpackage

`default_nettype wire

// File: rtl/sae_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sae_in_if import sae_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TIDX_W-1:0] table_index;
    logic [TVAL_W-1:0] table_value;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output op, output table_index, output table_value,
                    output symbol, input ready);
    modport sink   (input valid, input op, input table_index, input table_value,
                    input symbol, output ready);
endinterface

interface sae_out_if import sae_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              overflow;

    modport source (output valid, output out_byte, output last, output overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input overflow,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/sae_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sae_front import sae_pkg::*; #(
    parameter int TABLE_ENTRIES = 258
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sae_in_if.sink    i_in,
    output logic      o_q_valid,
    output t_cmd      o_q_cmd,
    input  wire       i_q_pop
);

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_cmd       r_mem [2];
    logic       keep;
    logic       push;
    t_cmd       cmd;

    always_comb begin
        cmd.op          = i_in.op;
        cmd.table_index = i_in.table_index;
        cmd.table_value = i_in.table_value;
        cmd.symbol      = i_in.symbol;
        unique case (i_in.op)
            OP_LOAD:   keep = 32'(i_in.table_index) < 32'(TABLE_ENTRIES);
            OP_ENCODE: keep = 1'b1;
            OP_FINISH: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready && keep;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sae_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sae_back import sae_pkg::*; #(
    parameter int CODE_BITS     = 16,
    parameter int TABLE_ENTRIES = 258,
    parameter int FREQ_BITS     = 14,
    parameter int PENDING_MAX   = 480
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [ENDSYM_W-1:0]  i_cfg_wdata,
    input  wire                 i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    input  wire                 i_busy,
    output t_wr                 o_w
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int CW1 = CODE_BITS + 1;
    localparam int DW  = CODE_BITS + 1 + FREQ_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int SW  = $clog2(CODE_BITS + 1);
    localparam int PW  = $clog2(PENDING_MAX + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDT   = 4'd1;
    localparam logic [3:0] S_RDH   = 4'd2;
    localparam logic [3:0] S_RDL   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_REN   = 4'd7;
    localparam logic [3:0] S_PEND  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [FREQ_BITS-1:0] r_table [TABLE_ENTRIES];
    logic [FREQ_BITS-1:0] r_rdata;
    logic                 r_rd_oor;

    logic [3:0]           r_state,  n_state;
    logic                 r_fin,    n_fin;
    logic [ENDSYM_W-1:0]  r_ch,     n_ch;
    logic [ENDSYM_W-1:0]  r_end_sym;
    logic [FREQ_BITS-1:0] r_total,  n_total;
    logic [FREQ_BITS-1:0] r_chi,    n_chi;
    logic [DW-1:0]        r_qhi,    n_qhi;
    logic [DW-1:0]        r_qlo,    n_qlo;
    logic [FREQ_BITS-1:0] r_rhi,    n_rhi;
    logic [FREQ_BITS-1:0] r_rlo,    n_rlo;
    logic [DCW-1:0]       r_dcnt,   n_dcnt;
    logic [CODE_BITS-1:0] r_low,    n_low;
    logic [CODE_BITS-1:0] r_high,   n_high;
    logic [PW-1:0]        r_pend,   n_pend;
    logic [BYTE_W-1:0]    r_buf,    n_buf;
    logic [FREE_W-1:0]    r_free,   n_free;
    logic [SW-1:0]        r_step,   n_step;
    logic                 r_pbit,   n_pbit;
    logic                 r_ret,    n_ret;
    logic                 r_ovf,    n_ovf;

    logic [RIDX_W-1:0]       ri;
    logic [RIDX_W+AW-1:0]    ri_ext;
    logic [AW-1:0]           ra;
    logic                    ra_oor;
    logic [TIDX_W+AW-1:0]    wa_ext;
    logic [AW-1:0]           wa;
    logic [TVAL_W+FREQ_BITS-1:0] wv_ext;
    logic [FREQ_BITS-1:0]    wv;
    logic                    tbl_we;
    logic [FREQ_BITS-1:0]    rdv;
    logic [CW1-1:0]          range_w;
    logic [DW-1:0]           prod_hi;
    logic [DW-1:0]           prod_lo;
    logic                    slice_ok;
    logic [FREQ_BITS:0]      t_hi, t_lo, d_hi, d_lo;
    logic                    ge_hi, ge_lo;
    logic [CW1-1:0]          sum_h, sum_l;
    logic                    put_en, put_val, flush, done;
    logic                    wr_en;
    logic [BYTE_W-1:0]       wr_data;
    logic [BYTE_W-1:0]       nb;
    logic                    fin_bit;

    always_comb begin
        unique case (r_state)
            S_RDH:   ri = {1'b0, r_ch};
            S_RDL:   ri = {1'b0, r_ch} + RIDX_W'(1);
            default: ri = '0;
        endcase
    end

    assign ri_ext = {{AW{1'b0}}, ri};
    assign ra     = ri_ext[AW-1:0];
    assign ra_oor = 32'(ri) >= 32'(TABLE_ENTRIES);
    assign wa_ext = {{AW{1'b0}}, i_q_cmd.table_index};
    assign wa     = wa_ext[AW-1:0];
    assign wv_ext = {{FREQ_BITS{1'b0}}, i_q_cmd.table_value};
    assign wv     = wv_ext[FREQ_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[wa] <= wv;
        end
        r_rdata  <= r_table[ra];
        r_rd_oor <= ra_oor;
    end

    assign rdv      = r_rd_oor ? '0 : r_rdata;
    assign range_w  = {1'b0, r_high} - {1'b0, r_low} + CW1'(1);
    assign prod_hi  = {{FREQ_BITS{1'b0}}, range_w} * {{CW1{1'b0}}, r_chi};
    assign prod_lo  = {{FREQ_BITS{1'b0}}, range_w} * {{CW1{1'b0}}, rdv};
    assign slice_ok = (r_total != '0) && (r_chi > rdv) && (r_chi <= r_total);

    assign t_hi  = {r_rhi, r_qhi[DW-1]};
    assign t_lo  = {r_rlo, r_qlo[DW-1]};
    assign ge_hi = t_hi >= {1'b0, r_total};
    assign ge_lo = t_lo >= {1'b0, r_total};
    assign d_hi  = t_hi - {1'b0, r_total};
    assign d_lo  = t_lo - {1'b0, r_total};

    assign sum_h   = {1'b0, r_low} + r_qhi[CODE_BITS:0] - CW1'(1);
    assign sum_l   = {1'b0, r_low} + r_qlo[CODE_BITS:0];
    assign fin_bit = r_low[CODE_BITS-1] | r_low[CODE_BITS-2];

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_ch    = r_ch;
        n_total = r_total;
        n_chi   = r_chi;
        n_qhi   = r_qhi;
        n_qlo   = r_qlo;
        n_rhi   = r_rhi;
        n_rlo   = r_rlo;
        n_dcnt  = r_dcnt;
        n_low   = r_low;
        n_high  = r_high;
        n_pend  = r_pend;
        n_buf   = r_buf;
        n_free  = r_free;
        n_step  = r_step;
        n_pbit  = r_pbit;
        n_ret   = r_ret;
        n_ovf   = r_ovf;
        put_en  = 1'b0;
        put_val = 1'b0;
        flush   = 1'b0;
        done    = 1'b0;
        o_q_pop = 1'b0;
        tbl_we  = 1'b0;
        wr_en   = 1'b0;
        wr_data = r_buf;
        nb      = {put_val, r_buf[BYTE_W-1:1]};

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !i_busy) begin
                    o_q_pop = 1'b1;
                    n_ovf   = 1'b0;
                    unique case (i_q_cmd.op)
                        OP_LOAD: begin
                            tbl_we  = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_ENCODE: begin
                            n_ch    = {1'b0, i_q_cmd.symbol};
                            n_fin   = 1'b0;
                            n_state = S_RDT;
                        end
                        OP_FINISH: begin
                            n_ch    = r_end_sym;
                            n_fin   = 1'b1;
                            n_state = S_RDT;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDT: n_state = S_RDH;
            S_RDH: begin
                n_total = rdv;
                n_state = S_RDL;
            end
            S_RDL: begin
                n_chi   = rdv;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (slice_ok) begin
                    n_qhi   = prod_hi;
                    n_qlo   = prod_lo;
                    n_rhi   = '0;
                    n_rlo   = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = r_fin ? S_FIN : S_DONE;
                end
            end
            S_DIV: begin
                n_rhi  = ge_hi ? d_hi[FREQ_BITS-1:0] : t_hi[FREQ_BITS-1:0];
                n_rlo  = ge_lo ? d_lo[FREQ_BITS-1:0] : t_lo[FREQ_BITS-1:0];
                n_qhi  = {r_qhi[DW-2:0], ge_hi};
                n_qlo  = {r_qlo[DW-2:0], ge_lo};
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(DW - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_high  = sum_h[CODE_BITS-1:0];
                n_low   = sum_l[CODE_BITS-1:0];
                n_step  = '0;
                n_state = S_REN;
            end
            S_REN: begin
                if (r_step == SW'(CODE_BITS)) begin
                    n_state = r_fin ? S_FIN : S_DONE;
                end else if (!r_high[CODE_BITS-1] || r_low[CODE_BITS-1]) begin
                    put_en  = 1'b1;
                    put_val = r_low[CODE_BITS-1];
                    n_low   = {r_low[CODE_BITS-2:0], 1'b0};
                    n_high  = {r_high[CODE_BITS-2:0], 1'b1};
                    n_step  = r_step + SW'(1);
                    n_pbit  = ~r_low[CODE_BITS-1];
                    n_ret   = 1'b1;
                    if (r_pend != '0) begin
                        n_state = S_PEND;
                    end
                end else if (r_low[CODE_BITS-2] && !r_high[CODE_BITS-2]) begin
                    if (r_pend >= PW'(PENDING_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pend = r_pend + PW'(1);
                    end
                    n_low  = {1'b0, r_low[CODE_BITS-3:0], 1'b0};
                    n_high = {1'b1, r_high[CODE_BITS-3:0], 1'b1};
                    n_step = r_step + SW'(1);
                end else begin
                    n_state = r_fin ? S_FIN : S_DONE;
                end
            end
            S_PEND: begin
                put_en  = 1'b1;
                put_val = r_pbit;
                n_pend  = r_pend - PW'(1);
                if (r_pend == PW'(1)) begin
                    n_state = r_ret ? S_REN : S_FLUSH;
                end
            end
            S_FIN: begin
                if (r_pend >= PW'(PENDING_MAX)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_pend = r_pend + PW'(1);
                end
                put_en  = 1'b1;
                put_val = fin_bit;
                n_pbit  = ~fin_bit;
                n_ret   = 1'b0;
                n_state = S_PEND;
            end
            S_FLUSH: begin
                flush   = 1'b1;
                n_low   = '0;
                n_high  = '1;
                n_pend  = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                done    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        nb = {put_val, r_buf[BYTE_W-1:1]};
        if (put_en) begin
            if (r_free == FREE_W'(1)) begin
                wr_en   = 1'b1;
                wr_data = nb;
                n_buf   = '0;
                n_free  = FREE_FULL;
            end else begin
                n_buf  = nb;
                n_free = r_free - FREE_W'(1);
            end
        end
        if (flush) begin
            wr_en   = 1'b1;
            wr_data = r_buf >> r_free;
            n_buf   = '0;
            n_free  = FREE_FULL;
        end
    end

    assign o_w.wr   = wr_en;
    assign o_w.data = wr_data;
    assign o_w.done = done;
    assign o_w.ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        r_fin   <= n_fin;
        r_ch    <= n_ch;
        r_total <= n_total;
        r_chi   <= n_chi;
        r_qhi   <= n_qhi;
        r_qlo   <= n_qlo;
        r_rhi   <= n_rhi;
        r_rlo   <= n_rlo;
        r_dcnt  <= n_dcnt;
        r_step  <= n_step;
        r_pbit  <= n_pbit;
        r_ret   <= n_ret;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_low     <= '0;
            r_high    <= '1;
            r_pend    <= '0;
            r_buf     <= '0;
            r_free    <= FREE_FULL;
            r_ovf     <= 1'b0;
            r_end_sym <= END_SYMBOL_RST;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
            r_pend  <= n_pend;
            r_buf   <= n_buf;
            r_free  <= n_free;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_end_sym <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sae_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module sae_obuf import sae_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_wr       i_w,
    output logic      o_busy,
    sae_out_if.source o_out
);

    logic [BYTE_W-1:0] r_mem [MAX_RESULTS];
    logic [RES_CW-1:0] r_wcnt;
    logic [RES_CW-1:0] r_total;
    logic [RES_CW-1:0] r_rcnt;
    logic              r_drain;
    logic              r_item_ovf;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_ovf;
    logic              wr_ok;
    logic              iss;
    logic [RES_CW-1:0] rcnt_inc;

    assign wr_ok    = i_w.wr && (r_wcnt < RES_CW'(MAX_RESULTS));
    assign iss      = r_drain && (!r_valid || o_out.ready);
    assign rcnt_inc = r_rcnt + RES_CW'(1);
    assign o_busy   = r_drain;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;
    assign o_out.overflow = r_ovf;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wcnt[RES_AW-1:0]] <= i_w.data;
        end
        if (iss) begin
            r_byte <= r_mem[r_rcnt[RES_AW-1:0]];
            r_last <= (rcnt_inc == r_total);
            r_ovf  <= r_item_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt     <= '0;
            r_total    <= '0;
            r_rcnt     <= '0;
            r_drain    <= 1'b0;
            r_item_ovf <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_w.done) begin
                r_wcnt <= '0;
                if (r_wcnt != '0) begin
                    r_drain    <= 1'b1;
                    r_total    <= r_wcnt;
                    r_rcnt     <= '0;
                    r_item_ovf <= i_w.ovf;
                end
            end else if (wr_ok) begin
                r_wcnt <= r_wcnt + RES_CW'(1);
            end
            if (iss) begin
                r_rcnt  <= rcnt_inc;
                r_valid <= 1'b1;
                if (rcnt_inc == r_total) begin
                    r_drain <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/static_arithmetic_encoder_top.sv
// Encode steps: table reads of the total and the slice bounds, a slice check, the bit-serial
// dual divider for quotients of CODE_BITS+FREQ_BITS+1 bits, a range update, and the
// renormalization steps with any pending bits, then leaving the loop and closing the item.
// Finish encodes the end symbol, then emits the final bit and its pending bits and flushes
// the last partial byte; load writes one table entry. Bytes leave one per cycle while ready.
// Throughput: one item at a time in the back end, set by the divider, the renorm loop and
// the drain of the item's bytes, which holds the next item.
// Reset: synchronous active low clears control state; the table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module static_arithmetic_encoder_top import sae_pkg::*; #(
    parameter int CODE_BITS     = 16,
    parameter int TABLE_ENTRIES = 258,
    parameter int FREQ_BITS     = 14,
    parameter int PENDING_MAX   = 480
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [ENDSYM_W-1:0] i_cfg_wdata,
    sae_in_if.sink             i_in,
    sae_out_if.source          o_out
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;
    logic busy;
    t_wr  w;

    sae_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    sae_back #(
        .CODE_BITS     (CODE_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FREQ_BITS     (FREQ_BITS),
        .PENDING_MAX   (PENDING_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_busy      (busy),
        .o_w         (w)
    );

    sae_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_w     (w),
        .o_busy  (busy),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue pop without entry");

    a_no_write_while_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w.wr && !w.done)
        else $error("byte transfer into buffer while draining");

    a_done_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w.done |=> !w.wr && !w.done)
        else $error("byte written right after item end");
`endif

endmodule

`default_nettype wire
